### hdl/fard_pkg.sv
// Shared types for the fraction ALU: operation codes and sequencer states.
package fard_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_D,
    ST_SUM,
    ST_GCD,
    ST_GCD_WAIT,
    ST_QNUM,
    ST_QNUM_WAIT,
    ST_QDEN,
    ST_QDEN_WAIT,
    ST_FIN
  } state_e;

endpackage

### hdl/fard_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
module fard_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[WIDTH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CW'(WIDTH);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_d = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### hdl/fraction_alu_reduce_core.sv
// Top level of the fraction ALU: cross-multiply, Euclid GCD, reduce.
//
// Takes two signed fractions a_num/a_den and b_num/b_den and an operation
// (add, subtract, multiply, divide), forms the raw numerator and denominator
// by cross-multiplying, then reduces both by their GCD. The GCD comes from
// Euclid's method with a remainder that truncates toward zero and keeps the
// dividend's sign; the GCD keeps its own sign, so the result signs follow
// from it (a negative GCD flips both parts). Zero over zero is returned as
// 0/0 with undefined_flag set; a nonzero numerator over zero gives 1/0.
// One request is worked at a time. It uses the shared
// IN_WIDTH x IN_WIDTH multiplier in ST_MUL_A, ST_MUL_B and ST_MUL_D, adds
// in ST_SUM, then runs E remainder steps of Euclid plus two exact divisions,
// each on one shared 2*IN_WIDTH-bit restoring divider that retires one
// bit per cycle, where E is the number of Euclid steps (up to roughly
// 3*IN_WIDTH for adverse operands). A finished result sits in the output
// register until taken; the next request is accepted meanwhile.
module fraction_alu_reduce_core #(
  parameter int IN_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic signed [IN_WIDTH-1:0]  a_num_i,
  input  logic signed [IN_WIDTH-1:0]  a_den_i,
  input  logic signed [IN_WIDTH-1:0]  b_num_i,
  input  logic signed [IN_WIDTH-1:0]  b_den_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [2*IN_WIDTH:0]  res_num_o,
  output logic signed [2*IN_WIDTH-1:0] res_den_o,
  output logic                        undefined_flag_o
);

  import fard_pkg::*;

  localparam int PW = 2 * IN_WIDTH;  // product width
  localparam int NW = PW + 1;        // raw numerator width

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // request operands
  op_e                       op_q, op_d;
  logic signed [IN_WIDTH-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;

  // products and Euclid working registers
  logic signed [PW-1:0] p0_q, p0_d, p1_q, p1_d;
  logic signed [NW-1:0] x_q, x_d, y_q, y_d;
  logic signed [NW-1:0] num_q, num_d, den_q, den_d;

  // reduced result before it moves to the output register
  logic signed [NW-1:0] rnum_q, rnum_d;
  logic signed [PW-1:0] rden_q, rden_d;
  logic                 rflag_q, rflag_d;

  logic signed [NW-1:0] res_num_q, res_num_d;
  logic signed [PW-1:0] res_den_q, res_den_d;
  logic                 flag_q, flag_d;

  // shared multiplier
  logic signed [IN_WIDTH-1:0] mul_a, mul_b;
  logic signed [PW-1:0]       mul_p;

  // magnitudes for the divider
  logic signed [NW-1:0] x_neg, y_neg, num_neg, den_neg;
  logic [PW-1:0]        x_abs, y_abs, num_abs, den_abs;

  // shared divider
  logic          div_start;
  logic [PW-1:0] div_dividend, div_divisor;
  logic          div_done;
  logic [PW-1:0] div_quot, div_rem;
  logic [NW-1:0] rem_ext, quot_ext;
  logic          q_neg;

  assign mul_p = mul_a * mul_b;

  assign x_neg   = -x_q;
  assign y_neg   = -y_q;
  assign num_neg = -num_q;
  assign den_neg = -den_q;
  assign x_abs   = x_q[NW-1]   ? x_neg[PW-1:0]   : x_q[PW-1:0];
  assign y_abs   = y_q[NW-1]   ? y_neg[PW-1:0]   : y_q[PW-1:0];
  assign num_abs = num_q[NW-1] ? num_neg[PW-1:0] : num_q[PW-1:0];
  assign den_abs = den_q[NW-1] ? den_neg[PW-1:0] : den_q[PW-1:0];

  assign rem_ext  = {1'b0, div_rem};
  assign quot_ext = {1'b0, div_quot};

  fard_div #(
    .WIDTH(PW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    x_d         = x_q;
    y_d         = y_q;
    num_d       = num_q;
    den_d       = den_q;
    rnum_d      = rnum_q;
    rden_d      = rden_q;
    rflag_d     = rflag_q;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    flag_d      = flag_q;
    mul_a       = an_q;
    mul_b       = bd_q;
    div_start   = 1'b0;
    div_dividend = x_abs;
    div_divisor  = y_abs;
    q_neg       = num_q[NW-1] ^ x_q[NW-1];
    in_ready_o  = 1'b0;

    // drop the output once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = op_e'(operation_i);
          an_d    = a_num_i;
          ad_d    = a_den_i;
          bn_d    = b_num_i;
          bd_d    = b_den_i;
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        mul_a   = an_q;
        mul_b   = (op_q == OP_MUL) ? bn_q : bd_q;
        p0_d    = mul_p;
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        mul_a   = bn_q;
        mul_b   = ad_q;
        p1_d    = mul_p;
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_a   = ad_q;
        mul_b   = (op_q == OP_DIV) ? bn_q : bd_q;
        y_d     = {mul_p[PW-1], mul_p};
        den_d   = {mul_p[PW-1], mul_p};
        state_d = ST_SUM;
      end
      ST_SUM: begin
        case (op_q)
          OP_ADD:  x_d = {p0_q[PW-1], p0_q} + {p1_q[PW-1], p1_q};
          OP_SUB:  x_d = {p0_q[PW-1], p0_q} - {p1_q[PW-1], p1_q};
          default: x_d = {p0_q[PW-1], p0_q};
        endcase
        num_d   = x_d;
        state_d = ST_GCD;
      end
      ST_GCD: begin
        // Euclid: finish on a zero remainder, else take one more remainder
        if (y_q == '0) begin
          if (x_q == '0) begin
            rnum_d  = '0;
            rden_d  = '0;
            rflag_d = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_QNUM;
          end
        end else begin
          div_start    = 1'b1;
          div_dividend = x_abs;
          div_divisor  = y_abs;
          state_d      = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (div_done) begin
          // remainder keeps the dividend's sign
          x_d     = y_q;
          y_d     = x_q[NW-1] ? -rem_ext : rem_ext;
          state_d = ST_GCD;
        end
      end
      ST_QNUM: begin
        div_start    = 1'b1;
        div_dividend = num_abs;
        div_divisor  = x_abs;
        state_d      = ST_QNUM_WAIT;
      end
      ST_QNUM_WAIT: begin
        if (div_done) begin
          q_neg   = num_q[NW-1] ^ x_q[NW-1];
          rnum_d  = q_neg ? -quot_ext : quot_ext;
          state_d = ST_QDEN;
        end
      end
      ST_QDEN: begin
        div_start    = 1'b1;
        div_dividend = den_abs;
        div_divisor  = x_abs;
        state_d      = ST_QDEN_WAIT;
      end
      ST_QDEN_WAIT: begin
        if (div_done) begin
          q_neg   = den_q[NW-1] ^ x_q[NW-1];
          rden_d  = q_neg ? -div_quot : div_quot;
          rflag_d = 1'b0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          res_num_d   = rnum_q;
          res_den_d   = rden_q;
          flag_d      = rflag_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    p0_q      <= p0_d;
    p1_q      <= p1_d;
    x_q       <= x_d;
    y_q       <= y_d;
    num_q     <= num_d;
    den_q     <= den_d;
    rnum_q    <= rnum_d;
    rden_q    <= rden_d;
    rflag_q   <= rflag_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    flag_q    <= flag_d;
  end

  assign out_valid_o      = out_valid_q;
  assign res_num_o        = res_num_q;
  assign res_den_o        = res_den_q;
  assign undefined_flag_o = flag_q;

endmodule

### tb/sv/fraction_alu_reduce_check.sv
// Checker for the fraction ALU: predicts each reduced fraction and compares the results.
module fraction_alu_reduce_check #(
  parameter int IN_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   operation_i,
  input  logic signed [IN_WIDTH-1:0]   a_num_i,
  input  logic signed [IN_WIDTH-1:0]   a_den_i,
  input  logic signed [IN_WIDTH-1:0]   b_num_i,
  input  logic signed [IN_WIDTH-1:0]   b_den_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [2*IN_WIDTH:0]   res_num_i,
  input  logic signed [2*IN_WIDTH-1:0] res_den_i,
  input  logic                         undefined_flag_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import fard_pkg::*;

  localparam int NUM_W = 2 * IN_WIDTH + 1;
  localparam int DEN_W = 2 * IN_WIDTH;

  typedef struct {
    logic signed [2*IN_WIDTH:0]   num;
    logic signed [2*IN_WIDTH-1:0] den;
    logic                         undef;
  } fraction_t;

  fraction_t   reduced_q[$];
  int unsigned mismatches;
  int unsigned result_idx;

  assign mismatch_count_o = mismatches;

  // Euclid with truncating remainder; the sign of the divisor is kept as it falls out.
  function automatic longint euclid_gcd(input longint x, input longint y);
    longint r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic fraction_t reduce_fraction(input op_e op,
                                                input logic signed [IN_WIDTH-1:0] an,
                                                input logic signed [IN_WIDTH-1:0] ad,
                                                input logic signed [IN_WIDTH-1:0] bn,
                                                input logic signed [IN_WIDTH-1:0] bd);
    longint    na, da, nb, db, num, den, g;
    fraction_t f;
    na = an;
    da = ad;
    nb = bn;
    db = bd;
    case (op)
      OP_ADD: begin
        num = na * db + nb * da;
        den = da * db;
      end
      OP_SUB: begin
        num = na * db - nb * da;
        den = da * db;
      end
      OP_MUL: begin
        num = na * nb;
        den = da * db;
      end
      default: begin
        num = na * db;
        den = da * nb;
      end
    endcase
    g = euclid_gcd(num, den);
    if (g == 0) begin
      f.num   = '0;
      f.den   = '0;
      f.undef = 1'b1;
    end else begin
      f.num   = NUM_W'(num / g);
      f.den   = DEN_W'(den / g);
      f.undef = 1'b0;
    end
    return f;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fraction_t want;
    if (!rst_ni) begin
      reduced_q.delete();
      mismatches = 0;
      result_idx = 0;
      pending_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (reduced_q.size() == 0) begin
          flag_error($sformatf("result %0d with nothing outstanding: %0d/%0d undef=%0b",
                               result_idx, res_num_i, res_den_i, undefined_flag_i));
        end else begin
          want = reduced_q.pop_front();
          if (res_num_i !== want.num || res_den_i !== want.den ||
              undefined_flag_i !== want.undef) begin
            flag_error($sformatf("result %0d: want %0d/%0d undef=%0b, got %0d/%0d undef=%0b",
                                 result_idx, want.num, want.den, want.undef,
                                 res_num_i, res_den_i, undefined_flag_i));
          end
        end
        result_idx++;
      end
      if (in_valid_i && in_ready_i) begin
        reduced_q.push_back(reduce_fraction(op_e'(operation_i), a_num_i, a_den_i,
                                            b_num_i, b_den_i));
      end
      pending_o <= reduced_q.size();
    end
  end

endmodule

### tb/sv/fraction_alu_reduce_core_test.sv
// Testbench top for the fraction ALU: drives requests, paces results, gives the verdict.
module fraction_alu_reduce_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fard_pkg::*;

  localparam int IN_W        = 16;
  localparam logic signed [IN_W-1:0] OPND_MAX = IN_W'(2 ** (IN_W - 1) - 1);
  localparam logic signed [IN_W-1:0] OPND_MIN = IN_W'(-(2 ** (IN_W - 1)));
  localparam int RANDOM_REQS = 1330;
  // Worst request: ~50 Euclid steps plus two divisions, each bit-serial on the
  // 32-bit divider, plus the longest idle on either side. Allow roughly ten times that.
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 2000;
  localparam int MAX_WAIT    = 12;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [1:0]               operation_i;
  logic signed [IN_W-1:0]   a_num_i;
  logic signed [IN_W-1:0]   a_den_i;
  logic signed [IN_W-1:0]   b_num_i;
  logic signed [IN_W-1:0]   b_den_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [2*IN_W:0]   res_num_o;
  logic signed [2*IN_W-1:0] res_den_o;
  logic                     undefined_flag_o;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned idle_cycles;

  fraction_alu_reduce_core #(
    .IN_WIDTH(IN_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .a_num_i         (a_num_i),
    .a_den_i         (a_den_i),
    .b_num_i         (b_num_i),
    .b_den_i         (b_den_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .res_num_o       (res_num_o),
    .res_den_o       (res_den_o),
    .undefined_flag_o(undefined_flag_o)
  );

  // The checker sees both channels exactly as the block does.
  fraction_alu_reduce_check #(
    .IN_WIDTH(IN_W)
  ) u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .operation_i     (operation_i),
    .a_num_i         (a_num_i),
    .a_den_i         (a_den_i),
    .b_num_i         (b_num_i),
    .b_den_i         (b_den_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .res_num_i       (res_num_o),
    .res_den_i       (res_den_o),
    .undefined_flag_i(undefined_flag_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: end the run once neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL fraction_alu_reduce_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Draw the idle time before the next transfer. Now and then start a calm
  // stretch in which the side never idles, so back-to-back traffic is hit too.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Mix operand shapes: zeros, extremes, small values, values with a shared
  // factor (so reduction really divides), and raw random bit patterns.
  function automatic logic signed [IN_W-1:0] draw_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 1;
          1:       return -1;
          2:       return OPND_MAX;
          default: return OPND_MIN;
        endcase
      end
      2, 3:    return IN_W'($signed($urandom_range(0, 48)) - 24);
      4, 5:    return IN_W'($signed($urandom_range(1, 60)) *
                            ($signed($urandom_range(0, 600)) - 300));
      default: return IN_W'($urandom());
    endcase
  endfunction

  int send_calm;

  // Present one request and hold it until it is taken. Enter and leave on a
  // rising edge; valid is only lowered when a gap really follows, so a
  // back-to-back request never sees valid dropped and raised in one step.
  task automatic send_request(input op_e op,
                              input logic signed [IN_W-1:0] an,
                              input logic signed [IN_W-1:0] ad,
                              input logic signed [IN_W-1:0] bn,
                              input logic signed [IN_W-1:0] bd);
    int gap;
    gap = draw_wait(send_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    a_num_i     <= an;
    a_den_i     <= ad;
    b_num_i     <= bn;
    b_den_i     <= bd;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Result side: once a result shows up, hold ready low for the drawn number
  // of cycles, then take it. A zero draw leaves ready high throughout.
  initial begin
    int stall;
    int take_calm;
    take_calm = 0;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = draw_wait(take_calm);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (stall - 1) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    send_calm   = 0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_ADD;
    a_num_i     <= '0;
    a_den_i     <= '0;
    b_num_i     <= '0;
    b_den_i     <= '0;
    rst_ni      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain cases of every operation.
    send_request(OP_ADD, 1, 2, 1, 3);
    send_request(OP_SUB, 5, 6, 1, 3);
    send_request(OP_MUL, -7, 3, 9, 14);
    send_request(OP_DIV, 3, 4, 9, 8);
    // Zero numerator over a nonzero denominator reduces to 0/1.
    send_request(OP_SUB, 1, 2, 1, 2);
    send_request(OP_MUL, 0, 5, 7, 3);
    // Zero over zero is flagged.
    send_request(OP_ADD, 0, 0, 0, 0);
    send_request(OP_MUL, 0, 5, 7, 0);
    send_request(OP_DIV, 0, 0, 0, 9);
    // Division by a zero fraction: nonzero over zero reduces to 1/0; 7/0 + -3/0 gives 0/0.
    send_request(OP_DIV, 3, 4, 0, 5);
    send_request(OP_ADD, 7, 0, -3, 0);
    // Negative denominators: a negative divisor out of Euclid flips both signs.
    send_request(OP_MUL, 3, -4, 1, 1);
    send_request(OP_ADD, 1, -2, 1, -2);
    send_request(OP_DIV, -7, 3, -7, 3);
    // Field extremes: the widest sums and products.
    send_request(OP_ADD, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN);
    send_request(OP_SUB, OPND_MIN, -1, OPND_MAX, OPND_MIN);
    send_request(OP_ADD, OPND_MIN, 1, OPND_MIN, 1);
    send_request(OP_MUL, OPND_MIN, OPND_MAX, OPND_MIN, OPND_MAX);
    send_request(OP_DIV, OPND_MAX, OPND_MIN, 1, OPND_MAX);
    send_request(OP_SUB, OPND_MAX, OPND_MIN, OPND_MIN, OPND_MAX);
    send_request(OP_MUL, -1, -1, -1, -1);
    send_request(OP_DIV, OPND_MIN, 1, -1, OPND_MIN);

    // Random requests: every operation, operands from the mixed shapes.
    repeat (RANDOM_REQS) begin
      send_request(op_e'($urandom_range(0, 3)), draw_operand(), draw_operand(),
                   draw_operand(), draw_operand());
    end
    in_valid_i <= 1'b0;

    // Let the checker count the last request, then drain.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0 && pending == 0) begin
      $display("PASS fraction_alu_reduce_core");
    end else begin
      $display("FAIL fraction_alu_reduce_core");
    end
    $finish;
  end

endmodule
